/* src/affine_matrix_with_inverse_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the affine matrix block
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_WITH_INVERSE_MACROS_SVH
`define AFFINE_MATRIX_WITH_INVERSE_MACROS_SVH
`ifndef SYNTHESIS
// check under reset disable
`define AMWI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check that also holds while in reset
`define AMWI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define AMWI_ASSERT(lbl, prop, msg)
`define AMWI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/amwi_pkg.sv */
// ----------------------------------------------------------------------------
// amwi_pkg
// Widths, CORDIC constants and shared types of the affine matrix block.
// ----------------------------------------------------------------------------
package amwi_pkg;

  localparam int TR_IN_W = 24;
  localparam int ANG_W   = 16;
  localparam int SC_W    = 16;
  localparam int CS_W    = 34;   // cos/sin, Q2.30 with headroom
  localparam int Z_W     = 33;   // residual angle
  localparam int FWD_W   = 32;
  localparam int TR_W    = 48;
  localparam int SUM_W   = 60;
  localparam int NUM_W   = 57;   // 2*|num| + |den|
  localparam int DEN_W   = 31;   // 2*|den|
  localparam int UD_W    = 30;
  localparam int LANES   = 6;
  localparam int TABLE_LEN = 24;

  localparam logic signed [CS_W-1:0] GAIN_Q30 = CS_W'(32'h26DD3B6A);

  // atan(2^-i) as a binary angle, 2^31 = pi
  function automatic logic signed [Z_W-1:0] arc_at(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return signed'({1'b0, v});
  endfunction

  typedef struct packed {
    logic neg;    // quotient sign
    logic dz;     // divisor is zero
    logic nneg;   // numerator negative
  } lane_flags_t;

  typedef struct packed {
    logic [FWD_W-1:0] fwd_a;
    logic [FWD_W-1:0] fwd_b;
    logic [FWD_W-1:0] fwd_c;
    logic [FWD_W-1:0] fwd_d;
    logic [TR_W-1:0]  fwd_tx;
    logic [TR_W-1:0]  fwd_ty;
    lane_flags_t [LANES-1:0] flags;
  } div_side_t;

endpackage

/* src/amwi_cordic.sv */
// ----------------------------------------------------------------------------
// amwi_cordic
// Unrolled rotation-mode CORDIC, one iteration per register stage.
// ----------------------------------------------------------------------------
module amwi_cordic import amwi_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SW    = 80
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [ANG_W-1:0]       angle_i,
  input  logic [SW-1:0]          side_i,
  output logic                   vld_o,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o,
  output logic [SW-1:0]          side_o
);

  logic signed [CS_W-1:0] x_q [STEPS+1];
  logic signed [CS_W-1:0] y_q [STEPS+1];
  logic signed [Z_W-1:0]  z_q [STEPS+1];
  logic                   flip_q [STEPS+1];
  logic [SW-1:0]          side_q [STEPS+1];
  logic [STEPS:0]         vld_q;
  logic                   vld_out_q;
  logic signed [CS_W-1:0] c_q, s_q;
  logic [SW-1:0]          side_out_q;
  logic                   flip_d;
  logic [31:0]            z0_d;

  // outer quadrants fold by pi; results are negated at the end
  assign flip_d = angle_i[15] ^ angle_i[14];
  assign z0_d   = {angle_i[15] ^ flip_d, angle_i[14:0], 16'h0000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[STEPS-1:0], vld_i};
      vld_out_q <= vld_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= GAIN_Q30;
      y_q[0]    <= '0;
      z_q[0]    <= signed'({z0_d[31], z0_d});
      flip_q[0] <= flip_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [CS_W-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][Z_W-1]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - arc_at(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + arc_at(5'(i));
        end
        flip_q[i+1] <= flip_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q        <= flip_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
      s_q        <= flip_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];
      side_out_q <= side_q[STEPS];
    end
  end

  assign vld_o  = vld_out_q;
  assign cos_o  = c_q;
  assign sin_o  = s_q;
  assign side_o = side_out_q;

endmodule

/* src/amwi_div.sv */
// ----------------------------------------------------------------------------
// amwi_div
// Pipelined restoring divider, several lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module amwi_div import amwi_pkg::*; #(
  parameter int NW = 57,
  parameter int DW = 31,
  parameter int SW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [LANES-1:0][NW-1:0]      num_i,
  input  logic [LANES-1:0][DW-1:0]      den_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          vld_o,
  output logic [LANES-1:0][NW-1:0]      quo_o,
  output logic [SW-1:0]                 side_o
);

  localparam int AW = DW + NW;

  // accumulator: remainder above, numerator bits shifting out, quotient shifting in
  logic [LANES-1:0][AW-1:0] acc_q [NW];
  logic [LANES-1:0][DW-1:0] den_q [NW];
  logic [SW-1:0]            side_q [NW];
  logic [NW-1:0]            vld_q;

  function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                            input logic [DW-1:0] den);
    logic [DW:0] hi;
    logic        qb;
    hi = acc[AW-1:NW-1];
    qb = (hi >= {1'b0, den});
    if (qb) hi = hi - {1'b0, den};
    return {hi[DW-1:0], acc[NW-2:0], qb};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        acc_q[0][l] <= div_step({{DW{1'b0}}, num_i[l]}, den_i[l]);
      end
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k < NW; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          acc_q[k][l] <= div_step(acc_q[k-1][l], den_q[k-1][l]);
        end
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = acc_q[NW-1][l][NW-1:0];
    end
  end

  assign vld_o  = vld_q[NW-1];
  assign side_o = side_q[NW-1];

endmodule

/* src/affine_matrix_with_inverse.sv */
// ----------------------------------------------------------------------------
// affine_matrix_with_inverse
// 2D affine matrix translate*rotate*scale and its inverse per beat.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   96     trans_x, trans_y, angle, scale_x, scale_y
// m_axis    out  448    forward matrix, then inverse matrix
//
// One beat in and one beat out per cycle, sustained while m_axis does not stall.
// Pipeline depth is set by one stage per CORDIC iteration and
// one per quotient bit of the 57-bit restoring divider.
// Reset clears only the valid bits of the pipeline.
// A stall at m_axis freezes every stage; s_axis_tready drops with it.
// ----------------------------------------------------------------------------
`include "affine_matrix_with_inverse_macros.svh"

module affine_matrix_with_inverse import amwi_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // trans_x, trans_y, angle, scale_x, scale_y
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fwd_a, fwd_b, fwd_c, fwd_d, fwd_tx, fwd_ty,
  // inv_a, inv_b, inv_c, inv_d, inv_tx, inv_ty
  output logic [447:0] m_axis_tdata
);

  localparam int CSW = 2 * TR_IN_W + 2 * SC_W;

  logic en;
  logic out_vld_q;
  logic [447:0] out_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---- CORDIC
  logic                   cor_vld;
  logic signed [CS_W-1:0] cor_c, cor_s;
  logic [CSW-1:0]         cor_side;

  amwi_cordic #(.STEPS(CORDIC_STEPS), .SW(CSW)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .angle_i(s_axis_tdata[63:48]),
    .side_i ({s_axis_tdata[95:64], s_axis_tdata[47:0]}),
    .vld_o  (cor_vld),
    .cos_o  (cor_c),
    .sin_o  (cor_s),
    .side_o (cor_side)
  );

  logic signed [TR_IN_W-1:0] tx, ty;
  logic signed [SC_W-1:0]    sx, sy;
  assign tx = cor_side[23:0];
  assign ty = cor_side[47:24];
  assign sx = cor_side[63:48];
  assign sy = cor_side[79:64];

  // ---- stage 1: products
  logic                      m1_vld_q;
  logic signed [49:0]        p_cx_q, p_sy_q, p_sx_q, p_cy_q;
  logic signed [57:0]        p_txc_q, p_tys_q, p_txs_q, p_tyc_q;
  logic signed [CS_W-1:0]    m1_c_q, m1_s_q;
  logic signed [TR_IN_W-1:0] m1_tx_q, m1_ty_q;
  logic signed [SC_W-1:0]    m1_sx_q, m1_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cx_q  <= cor_c * sx;
      p_sy_q  <= cor_s * sy;
      p_sx_q  <= cor_s * sx;
      p_cy_q  <= cor_c * sy;
      p_txc_q <= tx * cor_c;
      p_tys_q <= ty * cor_s;
      p_txs_q <= tx * cor_s;
      p_tyc_q <= ty * cor_c;
      m1_c_q  <= cor_c;
      m1_s_q  <= cor_s;
      m1_tx_q <= tx;
      m1_ty_q <= ty;
      m1_sx_q <= sx;
      m1_sy_q <= sy;
    end
  end

  // ---- stage 2: forward rounding, translation sums
  logic                   m2_vld_q;
  logic [FWD_W-1:0]       f_a_q, f_b_q, f_c_q, f_d_q;
  logic [TR_W-1:0]        f_tx_q, f_ty_q;
  logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
  logic signed [CS_W-1:0] m2_c_q, m2_s_q;
  logic signed [SC_W-1:0] m2_sx_q, m2_sy_q;
  logic signed [50:0]     r_a, r_b, r_c, r_d;

  localparam logic signed [50:0] HALF = 51'sd2097152;

  assign r_a = (51'(p_cx_q) + HALF) >>> 22;
  assign r_b = (-51'(p_sy_q) + HALF) >>> 22;
  assign r_c = (51'(p_sx_q) + HALF) >>> 22;
  assign r_d = (51'(p_cy_q) + HALF) >>> 22;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_a_q   <= r_a[FWD_W-1:0];
      f_b_q   <= r_b[FWD_W-1:0];
      f_c_q   <= r_c[FWD_W-1:0];
      f_d_q   <= r_d[FWD_W-1:0];
      f_tx_q  <= {{(TR_W-TR_IN_W-8){m1_tx_q[TR_IN_W-1]}}, m1_tx_q, 8'h00};
      f_ty_q  <= {{(TR_W-TR_IN_W-8){m1_ty_q[TR_IN_W-1]}}, m1_ty_q, 8'h00};
      sum_x_q <= -(SUM_W'(p_txc_q) + SUM_W'(p_tys_q));
      sum_y_q <= SUM_W'(p_txs_q) - SUM_W'(p_tyc_q);
      m2_c_q  <= m1_c_q;
      m2_s_q  <= m1_s_q;
      m2_sx_q <= m1_sx_q;
      m2_sy_q <= m1_sy_q;
    end
  end

  // ---- stage 3: magnitudes and divider operands
  logic signed [SUM_W-1:0] lane_num [LANES];
  logic [LANES-1:0]        lane_dy;     // divisor from scale_y
  logic [LANES-1:0]        lane_big;    // divisor scaled by 2^14
  logic [SC_W-1:0]         mag_sx, mag_sy;
  logic [LANES-1:0][NUM_W-1:0] n_d;
  logic [LANES-1:0][DEN_W-1:0] d_d;
  div_side_t               side_d;

  assign mag_sx = m2_sx_q[SC_W-1] ? SC_W'(-m2_sx_q) : m2_sx_q;
  assign mag_sy = m2_sy_q[SC_W-1] ? SC_W'(-m2_sy_q) : m2_sy_q;

  always_comb begin
    logic [SUM_W-1:0] un;
    logic [UD_W-1:0]  ud;
    logic             dneg;
    logic             dz;
    lane_num[0] = SUM_W'(m2_c_q);
    lane_num[1] = SUM_W'(m2_s_q);
    lane_num[2] = -SUM_W'(m2_s_q);
    lane_num[3] = SUM_W'(m2_c_q);
    lane_num[4] = sum_x_q;
    lane_num[5] = sum_y_q;
    lane_dy  = 6'b101100;
    lane_big = 6'b110000;
    side_d.fwd_a  = f_a_q;
    side_d.fwd_b  = f_b_q;
    side_d.fwd_c  = f_c_q;
    side_d.fwd_d  = f_d_q;
    side_d.fwd_tx = f_tx_q;
    side_d.fwd_ty = f_ty_q;
    for (int l = 0; l < LANES; l++) begin
      un = lane_num[l][SUM_W-1] ? -lane_num[l] : lane_num[l];
      if (lane_dy[l]) begin
        ud   = lane_big[l] ? {mag_sy, 14'h0} : {8'h00, mag_sy, 6'h00};
        dneg = m2_sy_q[SC_W-1];
        dz   = (m2_sy_q == '0);
      end else begin
        ud   = lane_big[l] ? {mag_sx, 14'h0} : {8'h00, mag_sx, 6'h00};
        dneg = m2_sx_q[SC_W-1];
        dz   = (m2_sx_q == '0);
      end
      n_d[l] = {un[NUM_W-2:0], 1'b0} + NUM_W'(ud);
      d_d[l] = {ud, 1'b0};
      side_d.flags[l].neg  = lane_num[l][SUM_W-1] ^ dneg;
      side_d.flags[l].dz   = dz;
      side_d.flags[l].nneg = lane_num[l][SUM_W-1];
    end
  end

  logic                        m3_vld_q;
  logic [LANES-1:0][NUM_W-1:0] m3_n_q;
  logic [LANES-1:0][DEN_W-1:0] m3_d_q;
  div_side_t                   m3_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_n_q    <= n_d;
      m3_d_q    <= d_d;
      m3_side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= cor_vld;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
    end
  end

  // ---- dividers
  logic                        div_vld;
  logic [LANES-1:0][NUM_W-1:0] div_q;
  div_side_t                   div_side;

  amwi_div #(.NW(NUM_W), .DW(DEN_W), .SW($bits(div_side_t))) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (m3_vld_q),
    .num_i  (m3_n_q),
    .den_i  (m3_d_q),
    .side_i (m3_side_q),
    .vld_o  (div_vld),
    .quo_o  (div_q),
    .side_o (div_side)
  );

  // ---- output: sign and zero-divisor saturation
  logic [TR_W-1:0] inv_r [LANES];

  always_comb begin
    logic [NUM_W-1:0] sq;
    for (int l = 0; l < LANES; l++) begin
      sq = div_side.flags[l].neg ? -div_q[l] : div_q[l];
      if (l < 4) begin
        if (div_side.flags[l].dz) begin
          inv_r[l] = div_side.flags[l].nneg ? TR_W'(32'h80000000) : TR_W'(32'h7FFFFFFF);
        end else begin
          inv_r[l] = TR_W'(sq[FWD_W-1:0]);
        end
      end else begin
        if (div_side.flags[l].dz) begin
          inv_r[l] = div_side.flags[l].nneg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
        end else begin
          inv_r[l] = sq[TR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {inv_r[5], inv_r[4],
                inv_r[3][FWD_W-1:0], inv_r[2][FWD_W-1:0],
                inv_r[1][FWD_W-1:0], inv_r[0][FWD_W-1:0],
                div_side.fwd_ty, div_side.fwd_tx,
                div_side.fwd_d, div_side.fwd_c, div_side.fwd_b, div_side.fwd_a};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  `AMWI_ASSERT(a_ready_follows_out, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "tready does not track output stall")
  `AMWI_ASSERT(a_div_to_out, (en && div_vld) |=> m_axis_tvalid, "divider beat lost before output")
  `AMWI_ASSERT(a_stall_freezes, (!en && m3_vld_q) |=> (m3_vld_q && $stable(m3_n_q)), "stage 3 moved during stall")
  `AMWI_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid || rst_ni, "output valid out of reset")

endmodule
